@@ hw/rtl/tsdg_pkg.sv @@
// Types, constants and sine table functions shared by the three-phase duty generator.
package tsdg_pkg;

  localparam int SineBits     = 10;
  localparam int DutyFracBits = 12;
  localparam int DutyW        = 13;
  localparam int SineW        = 13;
  localparam int AmpW         = 14;
  localparam int CfgW         = 24;
  localparam int CfgIdxW      = 2;
  localparam int CountW       = 24;
  localparam int QuarterSize  = 2 ** (SineBits - 2);
  localparam int ProdW        = AmpW + 1 + SineW;
  localparam int HalfNum      = 2 ** 24;
  localparam int DutyOne      = 2 ** DutyFracBits;
  localparam int DutyShift    = 25 - DutyFracBits;

  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  typedef enum logic [CfgIdxW-1:0] {
    RegPhaseStep = 2'd0,
    RegWrapLimit = 2'd1,
    RegAmplitude = 2'd2
  } tsdg_reg_e;

  typedef logic [11:0] tsdg_qtab_t [QuarterSize];

  typedef struct packed {
    logic [SineBits-1:0] idx_a;
    logic [SineBits-1:0] idx_b;
    logic [SineBits-1:0] idx_c;
  } tsdg_req_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_a;
    logic [DutyW-1:0] duty_b;
    logic [DutyW-1:0] duty_c;
  } tsdg_duty_t;

  // First-quadrant sine in Q12 from a truncated Q30 Taylor series.
  function automatic logic [11:0] quarter_sine(input logic [63:0] j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    longint      s;
    x  = (j * TwoPiQ30) >> SineBits;
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd210;
    s  = s - longint'(t);
    if (s < 0) begin
      s = 0;
    end
    r = (64'(s) + 64'd131072) >> 18;
    if (r > 64'd4095) begin
      r = 64'd4095;
    end
    return r[11:0];
  endfunction

  function automatic tsdg_qtab_t build_qtab();
    tsdg_qtab_t tab;
    for (int i = 0; i < QuarterSize; i++) begin
      tab[i] = quarter_sine(64'(i));
    end
    return tab;
  endfunction

  localparam tsdg_qtab_t  QuarterTab  = build_qtab();
  localparam logic [11:0] QuarterPeak = quarter_sine(64'(QuarterSize));

  // Full-turn signed Q12 sine built from the quarter table by symmetry.
  function automatic logic signed [SineW-1:0] sine_lookup(input logic [SineBits-1:0] idx);
    logic [SineBits-2:0]      h;
    logic [SineBits-2:0]      m;
    logic [11:0]              v;
    logic signed [SineW-1:0]  sv;
    h = idx[SineBits-2:0];
    // Past the quarter point the angle mirrors; modulo arithmetic gives half turn minus h.
    m = h[SineBits-2] ? (~h + 1'b1) : h;
    if (m[SineBits-2]) begin
      v = QuarterPeak;
    end else begin
      v = QuarterTab[m[SineBits-3:0]];
    end
    sv = {1'b0, v};
    return idx[SineBits-1] ? -sv : sv;
  endfunction

  // One half plus the scaled sine, shifted to the duty format and clamped to 0..1.
  function automatic logic [DutyW-1:0] duty_clamp(input logic signed [ProdW-1:0] prod);
    logic signed [ProdW:0] num;
    logic signed [ProdW:0] d;
    num = {prod[ProdW-1], prod} + (ProdW + 1)'(HalfNum);
    if (num < 0) begin
      return '0;
    end
    d = num >>> DutyShift;
    if (d > (ProdW + 1)'(DutyOne)) begin
      return DutyW'(DutyOne);
    end
    return d[DutyW-1:0];
  endfunction

endpackage

@@ hw/rtl/tsdg_queue.sv @@
// Two-entry first-in first-out buffer with full/empty style handshakes.
module tsdg_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_fire, rd_fire;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wr_fire ? ~wptr_q : wptr_q;
    rptr_d = rd_fire ? ~rptr_q : rptr_q;
    case ({wr_fire, rd_fire})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue occupancy exceeds two entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_fire && !rd_fire) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count did not grow on a lone write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_fire && !wr_fire) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("queue count did not shrink on a lone read");

endmodule

@@ hw/rtl/tsdg_front.sv @@
// Front end: configuration registers, sample counter, phase accumulator and table indices.
module tsdg_front #(
  parameter int PhaseBits = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsdg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsdg_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              tick_i,
  output logic                              in_ready_o,
  output logic                              req_valid_o,
  input  logic                              req_ready_i,
  output tsdg_pkg::tsdg_req_t               req_o,
  output logic [tsdg_pkg::AmpW-1:0]         amplitude_o
);
  import tsdg_pkg::*;

  localparam logic [PhaseBits-1:0] ThirdOffset =
    PhaseBits'(((64'd1 << PhaseBits) + 64'd1) / 64'd3);
  localparam logic [PhaseBits-1:0] TwoThirdOffset =
    PhaseBits'(((64'd1 << (PhaseBits + 1)) + 64'd1) / 64'd3);

  logic [PhaseBits-1:0] step_q;
  logic [CountW-1:0]    wrap_q;
  logic [AmpW-1:0]      amp_q;
  logic [CountW-1:0]    count_q, count_d;
  logic [PhaseBits-1:0] phase_q, phase_d;
  logic                 restart;
  logic                 take;
  logic [PhaseBits-1:0] ph_a, ph_b, ph_c;

  assign in_ready_o  = req_ready_i;
  assign req_valid_o = in_valid_i && tick_i;
  assign take        = req_valid_o && req_ready_i;
  assign amplitude_o = amp_q;

  always_comb begin
    // The wrap check comes before the lookup, so a restart tick reads phase zero.
    restart = (count_q >= wrap_q);
    ph_a    = restart ? '0 : phase_q;
    ph_b    = ph_a + ThirdOffset;
    ph_c    = ph_a + TwoThirdOffset;
    count_d = (restart ? '0 : count_q) + CountW'(1);
    phase_d = ph_a + step_q;
    req_o.idx_a = ph_a[PhaseBits-1 -: SineBits];
    req_o.idx_b = ph_b[PhaseBits-1 -: SineBits];
    req_o.idx_c = ph_c[PhaseBits-1 -: SineBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      wrap_q <= '0;
      amp_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (tsdg_reg_e'(cfg_idx_i))
        RegPhaseStep: step_q <= PhaseBits'(cfg_wdata_i);
        RegWrapLimit: wrap_q <= cfg_wdata_i[CountW-1:0];
        RegAmplitude: amp_q  <= cfg_wdata_i[AmpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= '0;
    end else if (take) begin
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ hw/rtl/tsdg_back.sv @@
// Back end: sine lookup, amplitude scaling and duty clamping in a two-stage pipeline.
module tsdg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  tsdg_pkg::tsdg_req_t       req_i,
  input  logic [tsdg_pkg::AmpW-1:0] amplitude_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output tsdg_pkg::tsdg_duty_t      res_o
);
  import tsdg_pkg::*;

  logic                    s1_v_q, s2_v_q;
  logic                    s1_ready, s2_ready;
  logic signed [SineW-1:0] sin_a_q, sin_b_q, sin_c_q;
  logic signed [ProdW-1:0] prod_a_q, prod_b_q, prod_c_q;
  logic signed [AmpW:0]    amp_s;

  assign amp_s       = {1'b0, amplitude_i};
  assign s2_ready    = !s2_v_q || res_ready_i;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign req_ready_o = s1_ready;
  assign res_valid_o = s2_v_q;

  always_comb begin
    res_o.duty_a = duty_clamp(prod_a_q);
    res_o.duty_b = duty_clamp(prod_b_q);
    res_o.duty_c = duty_clamp(prod_c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= req_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_valid_i) begin
      sin_a_q <= sine_lookup(req_i.idx_a);
      sin_b_q <= sine_lookup(req_i.idx_b);
      sin_c_q <= sine_lookup(req_i.idx_c);
    end
    if (s2_ready && s1_v_q) begin
      prod_a_q <= amp_s * sin_a_q;
      prod_b_q <= amp_s * sin_b_q;
      prod_c_q <= amp_s * sin_c_q;
    end
  end

endmodule

@@ hw/rtl/three_phase_sine_duty_generator.sv @@
// Top level of the three-phase sine duty generator.
//
//   channel   handshake           payload
//   input     push / full         tick_i
//   result    empty / pop         duty_a_o, duty_b_o, duty_c_o
//   config    cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// One tick is taken per clock cycle while full is low; its duties pass through the
// request queue, sine lookup stage, multiply stage and result queue in that order.
// Reset clears the counter, phase, config and valid state; no clearing pass is needed.
// A tick of zero is taken but gives no result and leaves the state unchanged.
// full rises only when the request queue holds two entries behind a stalled result side.
module three_phase_sine_duty_generator #(
  parameter int PhaseBits = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              tick_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [tsdg_pkg::DutyW-1:0]        duty_a_o,
  output logic [tsdg_pkg::DutyW-1:0]        duty_b_o,
  output logic [tsdg_pkg::DutyW-1:0]        duty_c_o,
  input  logic                              cfg_we_i,
  input  logic [tsdg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsdg_pkg::CfgW-1:0]         cfg_wdata_i
);
  import tsdg_pkg::*;

  logic            in_ready;
  logic            fr_valid, fr_ready;
  tsdg_req_t       fr_req;
  logic [AmpW-1:0] amplitude;
  logic            rq_valid, rq_ready;
  tsdg_req_t       rq_req;
  logic            bk_valid, bk_ready;
  tsdg_duty_t      bk_res;
  logic            out_valid;
  tsdg_duty_t      out_res;

  tsdg_front #(
    .PhaseBits(PhaseBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (push),
    .tick_i     (tick_i),
    .in_ready_o (in_ready),
    .req_valid_o(fr_valid),
    .req_ready_i(fr_ready),
    .req_o      (fr_req),
    .amplitude_o(amplitude)
  );

  tsdg_queue #(
    .Width($bits(tsdg_req_t))
  ) u_req_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_data_i (fr_req),
    .rd_valid_o(rq_valid),
    .rd_ready_i(rq_ready),
    .rd_data_o (rq_req)
  );

  tsdg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(rq_valid),
    .req_ready_o(rq_ready),
    .req_i      (rq_req),
    .amplitude_i(amplitude),
    .res_valid_o(bk_valid),
    .res_ready_i(bk_ready),
    .res_o      (bk_res)
  );

  tsdg_queue #(
    .Width($bits(tsdg_duty_t))
  ) u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(bk_valid),
    .wr_ready_o(bk_ready),
    .wr_data_i (bk_res),
    .rd_valid_o(out_valid),
    .rd_ready_i(pop),
    .rd_data_o (out_res)
  );

  assign full     = !in_ready;
  assign empty    = !out_valid;
  assign duty_a_o = out_res.duty_a;
  assign duty_b_o = out_res.duty_b;
  assign duty_c_o = out_res.duty_c;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the three-phase sine duty generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsdg_pkg::*;

  typedef longint unsigned u64_t;
  typedef enum logic {RowTick, RowWrite} row_op_e;

  typedef struct {
    row_op_e             op;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgW-1:0]     val;
    logic                tick;
    bit                  typed;
    tsdg_duty_t          duty;
  } plan_row_t;

  localparam int                  PhaseW        = 24;
  localparam int                  TableSize     = 1 << SineBits;
  localparam int                  HalfTable     = TableSize / 2;
  localparam int                  QuarterTable  = TableSize / 4;
  localparam logic [PhaseW-1:0]   ThirdTurn     = 24'd5592405;
  localparam logic [PhaseW-1:0]   TwoThirdTurn  = 24'd11184811;
  localparam logic [CfgIdxW-1:0]  RegUnused     = 2'd3;
  localparam logic [DutyW-1:0]    DutyHalf      = 13'd2048;
  localparam logic [DutyW-1:0]    DutyFull      = 13'd4096;
  localparam int                  DrainCycles   = 8;
  localparam int                  HoldCycles    = 80;
  localparam int                  WatchdogLimit = 3000;
  localparam int                  Segments      = 12;
  localparam int                  SegTicks      = 128;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  logic                tick_i      = 1'b0;
  logic                empty;
  logic                pop         = 1'b0;
  logic [DutyW-1:0]    duty_a_o;
  logic [DutyW-1:0]    duty_b_o;
  logic [DutyW-1:0]    duty_c_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  // Shadow of the block: registers, counter, phase and sine table.
  logic [PhaseW-1:0]        step_shadow = '0;
  logic [CountW-1:0]        wrap_shadow = '0;
  logic [AmpW-1:0]          amp_shadow  = '0;
  logic [CountW-1:0]        count_model = '0;
  logic [PhaseW-1:0]        phase_model = '0;
  logic signed [SineW-1:0]  sine_rom [TableSize];

  tsdg_duty_t  pending_duties [$];
  bit          typed_valid = 1'b0;
  tsdg_duty_t  typed_duties = '0;
  int          mismatches = 0;
  int          stalled_cycles = 0;
  int          idle_mode = 0;
  int          hold_requests = 0;
  int          holds_served = 0;

  three_phase_sine_duty_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .tick_i      (tick_i),
    .empty       (empty),
    .pop         (pop),
    .duty_a_o    (duty_a_o),
    .duty_b_o    (duty_b_o),
    .duty_c_o    (duty_c_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // First-quadrant sine in Q12, Taylor series in Q30 with every term truncated.
  function automatic logic [11:0] taylor_quarter(input int unsigned j);
    u64_t    x;
    u64_t    x2;
    u64_t    term;
    u64_t    r;
    longint  acc;
    x    = (u64_t'(j) * TwoPiQ30) >> SineBits;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (u64_t'(acc) + 64'd131072) >> 18;
    if (r > 64'd4095) begin
      r = 64'd4095;
    end
    return r[11:0];
  endfunction

  function automatic logic [DutyW-1:0] duty_at(input logic [PhaseW-1:0] ph);
    longint num;
    num = longint'(HalfNum)
        + longint'(amp_shadow) * longint'(sine_rom[ph[PhaseW-1 -: SineBits]]);
    if (num < 0) begin
      return '0;
    end
    num = num >>> DutyShift;
    if (num > longint'(DutyOne)) begin
      return DutyFull;
    end
    return num[DutyW-1:0];
  endfunction

  // Advances the shadow state by one tick and returns the three duties.
  function automatic tsdg_duty_t next_duties();
    tsdg_duty_t d;
    if (count_model >= wrap_shadow) begin
      count_model = '0;
      phase_model = '0;
    end
    d.duty_a    = duty_at(phase_model);
    d.duty_b    = duty_at(phase_model + ThirdTurn);
    d.duty_c    = duty_at(phase_model + TwoThirdTurn);
    count_model = count_model + 1'b1;
    phase_model = phase_model + step_shadow;
    return d;
  endfunction

  function automatic void compare_duty(input string field, input logic [DutyW-1:0] want,
                                       input logic [DutyW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic int idle_pct(input bit sender);
    case (idle_mode)
      0: return sender ? 28 : 53;
      1: return sender ? 53 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_cfg(input tsdg_reg_e which);
    int unsigned roll;
    roll = $urandom_range(0, 5);
    case (which)
      RegPhaseStep: begin
        case (roll)
          0: return '0;
          1: return '1;
          2: return CfgW'($urandom_range(1, 4096));
          default: return CfgW'($urandom());
        endcase
      end
      RegWrapLimit: begin
        case (roll)
          0: return '0;
          1: return '1;
          2: return CfgW'($urandom_range(1, 40));
          default: return CfgW'($urandom_range(41, 5000));
        endcase
      end
      default: begin
        case (roll)
          0: return '0;
          1: return CfgW'(16383);
          2: return CfgW'(4096);
          default: return CfgW'($urandom_range(0, 16383));
        endcase
      end
    endcase
  endfunction

  // Prediction and checking, both sampled at the rising edge.
  always @(posedge clk_i) begin : scoreboard
    tsdg_duty_t want;
    bit         busy;
    busy = 1'b0;
    if (cfg_we_i) begin
      busy = 1'b1;
      case (cfg_idx_i)
        RegPhaseStep: step_shadow = cfg_wdata_i[PhaseW-1:0];
        RegWrapLimit: wrap_shadow = cfg_wdata_i[CountW-1:0];
        RegAmplitude: amp_shadow  = cfg_wdata_i[AmpW-1:0];
        default: ;
      endcase
    end
    if (push && !full) begin
      busy = 1'b1;
      if (tick_i) begin
        want = next_duties();
        pending_duties.push_back(typed_valid ? typed_duties : want);
      end
    end
    if (pop && !empty) begin
      busy = 1'b1;
      if (pending_duties.size() == 0) begin
        $error("unexpected result transaction: a=%0d b=%0d c=%0d",
               duty_a_o, duty_b_o, duty_c_o);
        mismatches++;
      end else begin
        want = pending_duties.pop_front();
        compare_duty("duty_a", want.duty_a, duty_a_o);
        compare_duty("duty_b", want.duty_b, duty_b_o);
        compare_duty("duty_c", want.duty_c, duty_c_o);
      end
    end
    stalled_cycles = busy ? 0 : stalled_cycles + 1;
    if (stalled_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random pops, with a long hold-off whenever the sender asks for one.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  task automatic send_tick(input logic t, input bit typed, input tsdg_duty_t duties);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct(1'b1)) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    typed_valid  = typed;
    typed_duties = duties;
    push   <= 1'b1;
    tick_i <= t;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every tick has produced its result, then idles
  // for the drain period before it returns.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_duties.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  plan_row_t directed_plan [36] = '{
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyHalf, DutyHalf}},
    '{RowTick,  RegPhaseStep, '0,         1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyHalf, DutyHalf}},
    '{RowWrite, RegAmplitude, 24'd16383,  1'b0, 1'b0, '0},
    // Full-scale amplitude at phase zero saturates phase B high and phase C low.
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyFull, 13'd0}},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyFull, 13'd0}},
    '{RowWrite, RegPhaseStep, 24'hFFFFFF, 1'b0, 1'b0, '0},
    // A zero wrap limit restarts the phase on every tick.
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyFull, 13'd0}},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyFull, 13'd0}},
    '{RowWrite, RegWrapLimit, 24'hFFFFFF, 1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowWrite, RegAmplitude, 24'd4096,   1'b0, 1'b0, '0},
    '{RowWrite, RegPhaseStep, 24'h400000, 1'b0, 1'b0, '0},
    '{RowWrite, RegWrapLimit, 24'd3,      1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    // An unknown register index must leave every register alone.
    '{RowWrite, RegUnused,    24'hFFFFFF, 1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowWrite, RegAmplitude, 24'd0,      1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b1, '{DutyHalf, DutyHalf, DutyHalf}},
    '{RowWrite, RegAmplitude, 24'd2048,   1'b0, 1'b0, '0},
    '{RowWrite, RegPhaseStep, 24'd1,      1'b0, 1'b0, '0},
    '{RowWrite, RegWrapLimit, 24'd1,      1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b0, 1'b0, '0},
    '{RowTick,  RegPhaseStep, '0,         1'b1, 1'b0, '0}
  };

  initial begin : stimulus
    int          h;
    int          m;
    int          sent;
    logic [11:0] v;
    logic        t;
    for (int i = 0; i < TableSize; i++) begin
      h = (i < HalfTable) ? i : i - HalfTable;
      m = (h <= QuarterTable) ? h : HalfTable - h;
      v = taylor_quarter(m);
      sine_rom[i] = (i < HalfTable) ? $signed({1'b0, v}) : -$signed({1'b0, v});
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].op == RowWrite) begin
        settle();
        write_reg(directed_plan[r].reg_idx, directed_plan[r].val);
      end else begin
        send_tick(directed_plan[r].tick, directed_plan[r].typed, directed_plan[r].duty);
      end
    end

    for (int seg = 0; seg < Segments; seg++) begin
      idle_mode = seg / 4;
      settle();
      write_reg(RegPhaseStep, pick_cfg(RegPhaseStep));
      write_reg(RegWrapLimit, pick_cfg(RegWrapLimit));
      write_reg(RegAmplitude, pick_cfg(RegAmplitude));
      sent = 0;
      while (sent < SegTicks) begin
        t = ($urandom_range(0, 99) >= 8);
        send_tick(t, 1'b0, '0);
        if (t) begin
          sent++;
          // Sender pause until the pipeline has drained completely.
          if (seg == 1 && sent == 60) begin
            settle();
          end
          // Long receiver stall while ticks keep coming, so full must rise.
          if (seg == 8 && sent == 20) begin
            hold_requests++;
          end
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
